// ===== hdl/mlpf_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpf_pkg
// Shared constants and types of the multilevel priority FIFO.
// ----------------------------------------------------------------------------
package mlpf_pkg;

    // Both sizes are powers of two, so slot and level indexes concatenate
    // into a storage address and slot pointers wrap by truncation.
    localparam int LEVELS  = 8;
    localparam int DEPTH   = 8;
    localparam int LVL_W   = $clog2(LEVELS);
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ADDR_W  = LVL_W + SLOT_W;
    localparam int ENTRIES = LEVELS * DEPTH;
    localparam int DATA_W  = 32;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_t;

    // Result waiting for the storage read to return.
    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [LVL_W-1:0] level;
        logic             take_data;
    } stage_t;

endpackage

// ===== hdl/multilevel_priority_fifo.sv =====
// ----------------------------------------------------------------------------
// multilevel_priority_fifo
// Priority queue made of one circular FIFO per level, all held in one
// synchronous storage memory, with head pointers and counts in registers.
// ----------------------------------------------------------------------------
// Pipeline: a request transfer registers its pending result while the storage
// read runs; the result then moves into the output register.
// Throughput: one request per cycle while req_stall is low; head and count
// registers update at the transfer, so the next request sees the new occupancy.
// Reset: all levels become empty at once; the storage is not cleared, since
// no slot is read before it has been written.
module multilevel_priority_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic                        req_type,
    input  logic signed [31:0]          value,
    input  logic [2:0]                  level,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic [1:0]                  status,
    output logic signed [31:0]          removed_value,
    output logic [2:0]                  removed_level
);
    import mlpf_pkg::*;

    logic [DATA_W-1:0] mem [ENTRIES];
    logic [DATA_W-1:0] rdata_reg;

    logic [SLOT_W-1:0] head_reg [LEVELS];
    logic [SLOT_W-1:0] head_next [LEVELS];
    logic [CNT_W-1:0]  cnt_reg [LEVELS];
    logic [CNT_W-1:0]  cnt_next [LEVELS];

    stage_t s1_reg;
    stage_t s1_next;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [2:0]        out_level_reg;

    logic              accept;
    logic              s1_move;
    logic              found;
    logic [LVL_W-1:0]  sel_lvl;
    logic [LVL_W-1:0]  ins_lvl;
    logic              ins_ok;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign s1_move   = s1_reg.valid && (!out_valid_reg || !rsp_stall);
    assign req_stall = s1_reg.valid && !s1_move;
    assign accept    = req_valid && !req_stall;

    // Lowest-numbered non-empty level.
    always_comb
    begin
        found   = 1'b0;
        sel_lvl = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (!found && cnt_reg[l] != '0)
            begin
                found   = 1'b1;
                sel_lvl = LVL_W'(l);
            end
        end
    end

    assign ins_lvl = level[LVL_W-1:0];
    assign ins_ok  = (32'(level) < 32'(LEVELS)) && (cnt_reg[ins_lvl] < CNT_W'(DEPTH));

    always_comb
    begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        s1_next   = s1_reg;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        wr_addr   = {ins_lvl, SLOT_W'(head_reg[ins_lvl] + SLOT_W'(cnt_reg[ins_lvl]))};
        rd_addr   = {sel_lvl, head_reg[sel_lvl]};
        if (s1_move)
        begin
            s1_next.valid = 1'b0;
        end
        if (accept)
        begin
            s1_next.valid     = 1'b1;
            s1_next.level     = '0;
            s1_next.take_data = 1'b0;
            if (req_type == REQ_INSERT)
            begin
                if (ins_ok)
                begin
                    wr_en             = 1'b1;
                    cnt_next[ins_lvl] = cnt_reg[ins_lvl] + CNT_W'(1);
                    s1_next.status    = ST_INSERTED;
                end
                else
                begin
                    s1_next.status = ST_OVERFLOW;
                end
            end
            else if (found)
            begin
                rd_en              = 1'b1;
                head_next[sel_lvl] = head_reg[sel_lvl] + SLOT_W'(1);
                cnt_next[sel_lvl]  = cnt_reg[sel_lvl] - CNT_W'(1);
                s1_next.status     = ST_REMOVED;
                s1_next.level      = sel_lvl;
                s1_next.take_data  = 1'b1;
            end
            else
            begin
                s1_next.status = ST_EMPTY;
            end
        end
    end

    // Storage: a write and a read never fall in the same cycle, and the read
    // data holds until the next read, which only happens once it has moved on.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
            s1_reg.valid  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
            s1_reg   <= s1_next;
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_status_reg <= s1_reg.status;
            out_value_reg  <= s1_reg.take_data ? rdata_reg : '0;
            out_level_reg  <= 3'(s1_reg.level);
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign removed_value = out_value_reg;
    assign removed_level = out_level_reg;

    // A storage read always turns into a pending removal result.
    a_read_gives_removed: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> s1_reg.valid && s1_reg.status == ST_REMOVED && s1_reg.take_data)
        else $error("storage read without a pending removal result");

    // A remove transfer with every level empty reports an empty queue.
    a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req_type == REQ_REMOVE && !found |=> s1_reg.status == ST_EMPTY)
        else $error("remove from an empty queue not reported as empty");

    // Requests are held back only by a pending result that cannot move on.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_reg.valid && out_valid_reg && rsp_stall)
        else $error("request stalled without a blocked result");

    // The write and read of the storage never coincide.
    a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("storage read and write in the same cycle");

endmodule

// ===== tb/tb_multilevel_priority_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multilevel_priority_fifo
// Drives insert and remove requests into the multilevel priority FIFO with
// random gaps and response stalls. A scoreboard keeps its own copy of the
// per-level queues, predicts each response and checks it field by field.
// ----------------------------------------------------------------------------
module tb_multilevel_priority_fifo;
    import mlpf_pkg::*;

    typedef struct {
        status_t                   status;
        logic signed [DATA_W-1:0]  value;
        logic [LVL_W-1:0]          level;
    } outcome_t;

    class priority_scoreboard;
        logic [DATA_W-1:0] slots [LEVELS][DEPTH];
        logic [SLOT_W-1:0] head [LEVELS];
        logic [CNT_W-1:0]  count [LEVELS];
        outcome_t          outcome_q[$];
        int                errors;

        function new();
            foreach (head[l])
            begin
                head[l]  = '0;
                count[l] = '0;
            end
            errors = 0;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        // Applies one accepted request to the queue copy and records its outcome.
        function void note_request(req_t kind, logic signed [DATA_W-1:0] val,
                                   logic [LVL_W-1:0] lvl);
            outcome_t          o;
            logic [SLOT_W-1:0] tail;
            bit                found;
            o.status = ST_EMPTY;
            o.value  = '0;
            o.level  = '0;
            found    = 0;
            if (kind == REQ_INSERT)
            begin
                if (int'(lvl) >= LEVELS || count[lvl] >= DEPTH)
                    o.status = ST_OVERFLOW;
                else
                begin
                    tail = head[lvl] + SLOT_W'(count[lvl]);
                    slots[lvl][tail] = val;
                    count[lvl]++;
                    o.status = ST_INSERTED;
                end
            end
            else
            begin
                for (int l = 0; l < LEVELS; l++)
                begin
                    if (!found && count[l] != 0)
                    begin
                        o.value  = slots[l][head[l]];
                        o.level  = LVL_W'(l);
                        o.status = ST_REMOVED;
                        head[l]++;
                        count[l]--;
                        found = 1;
                    end
                end
            end
            outcome_q.push_back(o);
        endfunction

        function void check_result(status_t st, logic signed [DATA_W-1:0] val,
                                   logic [LVL_W-1:0] lvl);
            outcome_t o;
            if (outcome_q.size() == 0)
            begin
                $error("response with no request outstanding: status %0d", st);
                errors++;
                return;
            end
            o = outcome_q.pop_front();
            if (st !== o.status)
            begin
                $error("status: expected %0d, got %0d", o.status, st);
                errors++;
            end
            if (val !== o.value)
            begin
                $error("removed_value: expected %0d, got %0d", o.value, val);
                errors++;
            end
            if (lvl !== o.level)
            begin
                $error("removed_level: expected %0d, got %0d", o.level, lvl);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    logic                     req_type;
    logic signed [DATA_W-1:0] value;
    logic [LVL_W-1:0]         level;
    logic                     rsp_valid;
    logic                     rsp_stall;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] removed_value;
    logic [LVL_W-1:0]         removed_level;

    priority_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int results_seen;
    int hold_left;
    bit hold_done;

    multilevel_priority_fifo uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .value         (value),
        .level         (level),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .removed_value (removed_value),
        .removed_level (removed_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // Offers one request, with random idle cycles ahead of it, and records it
    // in the scoreboard once the transfer has happened.
    task automatic send_request(req_t kind, logic signed [DATA_W-1:0] val,
                                logic [LVL_W-1:0] lvl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        value     <= val;
        level     <= lvl;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(kind, val, lvl);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // Random requests in short runs, each run with its own insert ratio and
    // level spread, so the queue drains, fills and overflows in turn.
    task automatic random_requests(int n);
        int   insert_pct;
        int   focus_level;
        int   spread;
        req_t kind;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(3))
                    0:       insert_pct = 25;
                    1:       insert_pct = 50;
                    2:       insert_pct = 75;
                    default: insert_pct = 95;
                endcase
                focus_level = $urandom_range(LEVELS - 1);
                spread      = $urandom_range(2) == 0 ? 0 :
                              ($urandom_range(1) == 0 ? 1 : LEVELS - 1);
            end
            kind = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
            send_request(kind, pick_value(),
                         LVL_W'(focus_level + $urandom_range(spread)));
        end
    endtask

    // Response side: checks every transfer and decides the stall for the next
    // cycle. One long hold-off lets the block fill and stall its request side.
    initial
    begin
        results_seen = 0;
        hold_left    = 0;
        hold_done    = 0;
        rsp_stall   <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                sb.check_result(status_t'(status), removed_value, removed_level);
                results_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (results_seen >= 400 && !hold_done)
            begin
                hold_done = 1;
                hold_left = 300;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        sb = new();
        send_idle_pct  = 35;
        recv_stall_pct = 60;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_type  <= REQ_INSERT;
        value     <= '0;
        level     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue, priority order across levels and the value extremes.
        send_request(REQ_REMOVE, 32'sd5, 3'd2);
        send_request(REQ_INSERT, 32'sh7fff_ffff, 3'd3);
        send_request(REQ_INSERT, 32'sh8000_0000, 3'd0);
        send_request(REQ_REMOVE, 32'sd0, 3'd0);
        send_request(REQ_REMOVE, -32'sd1, 3'd7);
        send_request(REQ_REMOVE, 32'sd0, 3'd0);
        // Fill the lowest-priority level; the last insert overflows.
        for (int i = 0; i <= DEPTH; i++)
            send_request(REQ_INSERT, (i % 2 == 0) ? -32'sd1 - i : 32'sd97 + i, 3'd7);
        send_request(REQ_INSERT, 32'sd0, 3'd5);
        send_request(REQ_INSERT, -32'sd1, 3'd1);
        send_request(REQ_REMOVE, 32'sd0, 3'd0);
        send_request(REQ_REMOVE, 32'sd0, 3'd0);
        send_request(REQ_REMOVE, 32'sd0, 3'd0);

        random_requests(550);
        send_idle_pct  = 60;
        recv_stall_pct = 35;
        random_requests(550);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_requests(550);
        req_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== multilevel_priority_fifo.f =====
hdl/mlpf_pkg.sv
hdl/multilevel_priority_fifo.sv
tb/tb_multilevel_priority_fifo.sv
